>>> design/bfbp_pkg.sv
// Shared constants, status codes and controller/datapath signal groups for the buffer pool.
package bfbp_pkg;

  // Default table depth and address width.
  localparam int BFBP_SLOTS     = 16;
  localparam int BFBP_ADDR_BITS = 48;

  // Fixed field widths of the channels.
  localparam int BYTES_W  = 32;
  localparam int STATUS_W = 3;
  localparam int INDEX_W  = 4;
  localparam int LIMIT_W  = 5;

  // Request kinds.
  localparam logic REQ_ALLOC   = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_REUSED      = 3'd0,
    ST_NEW         = 3'd1,
    ST_ALLOC_FAIL  = 3'd2,
    ST_POOL_FULL   = 3'd3,
    ST_RELEASED    = 3'd4,
    ST_NOT_IN_POOL = 3'd5
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;   // latch the request and clear the scan result
    logic issue;   // read the slot at the scan pointer and advance it
    logic commit;  // apply the decision and load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;      // no slots in the pool yet
    logic scan_last;  // the scan pointer is at the last slot in use
    logic out_free;   // the result register can take a new item
  } stat_t;

endpackage

>>> design/bfbp_req_if.sv
// Request channel: valid/ready handshake carrying one allocate or release item.
interface bfbp_req_if
  import bfbp_pkg::*;
#(
  parameter int ADDR_BITS = BFBP_ADDR_BITS
) ();
  logic                 valid;
  logic                 ready;
  logic                 req_type;
  logic [BYTES_W-1:0]   req_bytes;
  logic [ADDR_BITS-1:0] fresh_base;
  logic                 fresh_ok;
  logic [ADDR_BITS-1:0] release_addr;

  modport source (output valid, req_type, req_bytes, fresh_base, fresh_ok, release_addr,
                  input ready);
  modport sink (input valid, req_type, req_bytes, fresh_base, fresh_ok, release_addr,
                output ready);
endinterface

>>> design/bfbp_rsp_if.sv
// Result channel: valid/ready handshake carrying one result item.
interface bfbp_rsp_if
  import bfbp_pkg::*;
#(
  parameter int ADDR_BITS = BFBP_ADDR_BITS
) ();
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [INDEX_W-1:0]   slot_index;
  logic [ADDR_BITS-1:0] base_addr;
  logic [BYTES_W-1:0]   grant_bytes;

  modport source (output valid, status, slot_index, base_addr, grant_bytes, input ready);
  modport sink (input valid, status, slot_index, base_addr, grant_bytes, output ready);
endinterface

>>> design/bfbp_cfg_if.sv
// Configuration write channel: valid/ready handshake carrying the entry limit.
interface bfbp_cfg_if
  import bfbp_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [LIMIT_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

>>> design/bfbp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module bfbp_ram
  import bfbp_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = BFBP_SLOTS
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/bfbp_ctrl.sv
// Controller state machine: sequences accept, slot scan, decision and result hand-off.
module bfbp_ctrl
  import bfbp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = stat.empty ? S_FINISH : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        if (stat.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // The last slot read is being examined this cycle.
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> design/bfbp_dp.sv
// Datapath: request register, slot table, best-fit and address-match scan, result register.
module bfbp_dp
  import bfbp_pkg::*;
#(
  parameter int SLOTS     = BFBP_SLOTS,
  parameter int ADDR_BITS = BFBP_ADDR_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output stat_t                stat,
  // Request fields
  input  logic                 in_type,
  input  logic [BYTES_W-1:0]   in_bytes,
  input  logic [ADDR_BITS-1:0] in_fresh_base,
  input  logic                 in_fresh_ok,
  input  logic [ADDR_BITS-1:0] in_release_addr,
  // Configuration write
  input  logic                 cfg_we,
  input  logic [LIMIT_W-1:0]   cfg_data,
  // Result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [STATUS_W-1:0]  out_status,
  output logic [INDEX_W-1:0]   out_index,
  output logic [ADDR_BITS-1:0] out_base,
  output logic [BYTES_W-1:0]   out_bytes
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;
  localparam int RW = ADDR_BITS + BYTES_W;

  // Latched request.
  logic                 r_type;
  logic [BYTES_W-1:0]   r_bytes;
  logic [ADDR_BITS-1:0] r_fresh_base;
  logic                 r_fresh_ok;
  logic [ADDR_BITS-1:0] r_addr;

  // Pool state and configuration.
  logic [LIMIT_W-1:0] max_entries;
  logic [CW-1:0]      slot_count;
  logic [SLOTS-1:0]   slot_busy;

  // Scan pipeline and best candidate so far.
  logic [IW-1:0]        ptr;
  logic                 chk_valid;
  logic [IW-1:0]        chk_idx;
  logic                 found;
  logic [IW-1:0]        cand_idx;
  logic [BYTES_W-1:0]   best_cap;
  logic [ADDR_BITS-1:0] best_base;

  // Table memory: base address over capacity.
  logic          ram_we;
  logic [RW-1:0] ram_rdata;

  bfbp_ram #(
    .WIDTH (RW),
    .DEPTH (SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_count[IW-1:0]),
    .wdata ({r_fresh_base, r_bytes}),
    .raddr (ptr),
    .rdata (ram_rdata)
  );

  logic [BYTES_W-1:0]   rd_cap;
  logic [ADDR_BITS-1:0] rd_base;
  logic                 fits;
  logic                 take;
  logic [CW:0]          ptr_plus;

  assign rd_cap  = ram_rdata[BYTES_W-1:0];
  assign rd_base = ram_rdata[RW-1:BYTES_W];

  // Candidate test for the slot whose data has just been read.
  assign fits = !slot_busy[chk_idx] && (rd_cap >= r_bytes);
  always_comb begin
    if (r_type == REQ_RELEASE) begin
      take = chk_valid && !found && (rd_base == r_addr) && (r_addr != '0);
    end else begin
      take = chk_valid && fits && (!found || (rd_cap < best_cap));
    end
  end

  // Status towards the controller.
  assign ptr_plus       = (CW + 1)'(ptr) + 1'b1;
  assign stat.empty     = (slot_count == '0);
  assign stat.scan_last = (ptr_plus == (CW + 1)'(slot_count));
  assign stat.out_free  = !out_valid || out_ready;

  // Effective entry limit; zero or too large means the whole table.
  logic [LW-1:0] limit;
  logic          room;
  always_comb begin
    if ((max_entries == '0) || (LW'(max_entries) > LW'(SLOTS))) begin
      limit = LW'(SLOTS);
    end else begin
      limit = LW'(max_entries);
    end
  end
  assign room = LW'(slot_count) < limit;

  // Decision at the end of the scan.
  status_t              res_status;
  logic [IW-1:0]        res_idx;
  logic [ADDR_BITS-1:0] res_base;
  logic [BYTES_W-1:0]   res_bytes;
  logic                 do_new;

  always_comb begin
    res_status = ST_NOT_IN_POOL;
    res_idx    = '0;
    res_base   = '0;
    res_bytes  = '0;
    do_new     = 1'b0;
    if (r_type == REQ_RELEASE) begin
      if (found) begin
        res_status = ST_RELEASED;
        res_idx    = cand_idx;
        res_base   = best_base;
        res_bytes  = best_cap;
      end
    end else if (found) begin
      res_status = ST_REUSED;
      res_idx    = cand_idx;
      res_base   = best_base;
      res_bytes  = best_cap;
    end else if (room) begin
      if (r_fresh_ok) begin
        do_new     = 1'b1;
        res_status = ST_NEW;
        res_idx    = slot_count[IW-1:0];
        res_base   = r_fresh_base;
        res_bytes  = r_bytes;
      end else begin
        res_status = ST_ALLOC_FAIL;
      end
    end else begin
      res_status = ST_POOL_FULL;
    end
  end

  assign ram_we = cmd.commit && do_new;

  // Request register.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      r_type       <= in_type;
      r_bytes      <= in_bytes;
      r_fresh_base <= in_fresh_base;
      r_fresh_ok   <= in_fresh_ok;
      r_addr       <= in_release_addr;
    end
  end

  // Scan control: pointer, read tracking and the best candidate flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr       <= '0;
      chk_valid <= 1'b0;
      found     <= 1'b0;
    end else begin
      chk_valid <= cmd.issue;
      if (cmd.start) begin
        ptr   <= '0;
        found <= 1'b0;
      end else begin
        if (cmd.issue) begin
          ptr <= ptr + 1'b1;
        end
        if (take) begin
          found <= 1'b1;
        end
      end
    end
  end

  // Scan payload: index in flight and the chosen slot's contents.
  always_ff @(posedge clk) begin
    chk_idx <= ptr;
    if (take) begin
      cand_idx  <= chk_idx;
      best_cap  <= rd_cap;
      best_base <= rd_base;
    end
  end

  // Pool state: limit register, slot count and busy marks.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries <= '0;
      slot_count  <= '0;
      slot_busy   <= '0;
    end else begin
      if (cfg_we) begin
        max_entries <= cfg_data;
      end
      if (cmd.commit) begin
        if (do_new) begin
          slot_count <= slot_count + 1'b1;
          slot_busy[slot_count[IW-1:0]] <= 1'b1;
        end else if (found) begin
          slot_busy[cand_idx] <= (r_type == REQ_ALLOC);
        end
      end
    end
  end

  // Result register: holds an item until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status <= res_status;
      out_index  <= INDEX_W'(res_idx);
      out_base   <= res_base;
      out_bytes  <= res_bytes;
    end
  end

endmodule

>>> design/best_fit_buffer_pool.sv
// Top level of the best-fit buffer pool: channel wiring of controller and datapath.
//
// The pool keeps up to SLOTS buffer slots (base, capacity, busy mark). On the
// req channel an item is either an allocate (req_type 0: req_bytes, plus
// fresh_base/fresh_ok from the external allocator for a possible new slot) or
// a release (req_type 1: release_addr). Each item gives exactly one result item
// on the rsp channel with a status, slot index, base address and byte count.
// The cfg channel writes the entry limit; it is always ready and should only be
// written while no request is in flight.
// Each request reads the slots in use one per cycle through the table RAM's
// single registered read port. The controller steps from idle through scan and
// drain to finish, where the decision is loaded into the result register, and
// then back to idle, where req is ready again; with an empty pool it goes from
// idle straight to finish. Requests are handled one at a time; the next item is
// accepted while a result still waits.
// If the receiver stalls, the result is held and the following request is
// accepted and scanned, then waits for the result register to empty.
// Reset (rst, synchronous) empties the pool, clears every busy mark, sets the
// limit to zero (whole table) and drops any pending result.
module best_fit_buffer_pool
  import bfbp_pkg::*;
#(
  parameter int SLOTS     = BFBP_SLOTS,
  parameter int ADDR_BITS = BFBP_ADDR_BITS
) (
  input logic       clk,
  input logic       rst,
  bfbp_req_if.sink  req,
  bfbp_rsp_if.source rsp,
  bfbp_cfg_if.sink  cfg
);

  cmd_t  cmd;
  stat_t stat;

  // The limit register takes a write in any cycle.
  assign cfg.ready = 1'b1;

  bfbp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bfbp_dp #(
    .SLOTS     (SLOTS),
    .ADDR_BITS (ADDR_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .in_type         (req.req_type),
    .in_bytes        (req.req_bytes),
    .in_fresh_base   (req.fresh_base),
    .in_fresh_ok     (req.fresh_ok),
    .in_release_addr (req.release_addr),
    .cfg_we          (cfg.valid),
    .cfg_data        (cfg.data),
    .out_valid       (rsp.valid),
    .out_ready       (rsp.ready),
    .out_status      (rsp.status),
    .out_index       (rsp.slot_index),
    .out_base        (rsp.base_addr),
    .out_bytes       (rsp.grant_bytes)
  );

endmodule

>>> bench/tb_top.sv
// Testbench for the best-fit buffer pool: directed and random requests checked against a local model.
module tb_top;
  import bfbp_pkg::*;

  localparam int SLOTS       = BFBP_SLOTS;
  localparam int ADDR_W      = BFBP_ADDR_BITS;
  localparam int HALF_PERIOD = 6;
  localparam int RUN_CYCLES  = 800000;
  localparam int TAIL_CYCLES = 25;

  // One request as the sender sees it.
  typedef struct {
    logic               kind;
    logic [BYTES_W-1:0] bytes;
    logic [ADDR_W-1:0]  fresh_base;
    logic               fresh_ok;
    logic [ADDR_W-1:0]  release_addr;
  } pool_req_t;

  // One result item of the pool.
  typedef struct {
    status_t            status;
    logic [INDEX_W-1:0] index;
    logic [ADDR_W-1:0]  base;
    logic [BYTES_W-1:0] bytes;
  } pool_rsp_t;

  logic clk;
  logic rst;

  bfbp_req_if req_if ();
  bfbp_rsp_if rsp_if ();
  bfbp_cfg_if cfg_if ();

  best_fit_buffer_pool DUT (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if),
    .cfg (cfg_if)
  );

  // Local copy of the slot table and the entry limit.
  logic [ADDR_W-1:0]  pool_base [SLOTS];
  logic [BYTES_W-1:0] pool_cap  [SLOTS];
  bit                 pool_busy [SLOTS];
  int                 pool_used;
  logic [LIMIT_W-1:0] entry_limit;

  // Outcomes of accepted requests, oldest first.
  pool_rsp_t outcomes_due[$];

  int send_idle_pct;
  int recv_idle_pct;
  int requests_sent;
  int results_seen;
  int mismatches;
  int status_seen [6];

  // Clock.
  initial begin
    clk = 1'b0;
    forever #HALF_PERIOD clk = ~clk;
  end

  // Overall time limit.
  initial begin
    #(2 * HALF_PERIOD * RUN_CYCLES);
    $display("tb_top: done, errors");
    $finish;
  end

  // Works out the result of one request and updates the local slot table.
  function automatic pool_rsp_t pool_outcome(input pool_req_t r);
    pool_rsp_t res;
    int        limit;
    int        best;
    int        i;
    bit        hit;
    res  = '{ST_NOT_IN_POOL, '0, '0, '0};
    best = -1;
    hit  = 1'b0;
    if (r.kind == REQ_ALLOC) begin
      limit = (entry_limit == 0 || entry_limit > SLOTS) ? SLOTS : int'(entry_limit);
      // Smallest free slot that is large enough; the strict compare keeps the lowest index.
      for (i = 0; i < pool_used; i++) begin
        if (!pool_busy[i] && pool_cap[i] >= r.bytes &&
            (best < 0 || pool_cap[i] < pool_cap[best])) begin
          best = i;
        end
      end
      if (best >= 0) begin
        pool_busy[best] = 1'b1;
        res = '{ST_REUSED, INDEX_W'(best), pool_base[best], pool_cap[best]};
      end else if (pool_used < limit) begin
        if (r.fresh_ok) begin
          pool_base[pool_used] = r.fresh_base;
          pool_cap[pool_used]  = r.bytes;
          pool_busy[pool_used] = 1'b1;
          res = '{ST_NEW, INDEX_W'(pool_used), r.fresh_base, r.bytes};
          pool_used++;
        end else begin
          res = '{ST_ALLOC_FAIL, '0, '0, '0};
        end
      end else begin
        res = '{ST_POOL_FULL, '0, '0, '0};
      end
    end else if (r.release_addr != '0) begin
      // The lowest slot with a matching base is freed, whether busy or not.
      for (i = 0; i < pool_used; i++) begin
        if (!hit && pool_base[i] == r.release_addr) begin
          hit = 1'b1;
          pool_busy[i] = 1'b0;
          res = '{ST_RELEASED, INDEX_W'(i), pool_base[i], pool_cap[i]};
        end
      end
    end
    return res;
  endfunction

  function automatic pool_req_t alloc_req(input logic [BYTES_W-1:0] bytes,
                                          input logic [ADDR_W-1:0] base, input logic ok);
    pool_req_t r;
    r = '{REQ_ALLOC, bytes, base, ok, ADDR_W'({$urandom(), $urandom()})};
    return r;
  endfunction

  function automatic pool_req_t release_req(input logic [ADDR_W-1:0] addr);
    pool_req_t r;
    r = '{REQ_RELEASE, $urandom(), ADDR_W'({$urandom(), $urandom()}), 1'($urandom()), addr};
    return r;
  endfunction

  // Random request, weighted towards sizes and addresses already in the table.
  function automatic pool_req_t random_request();
    pool_req_t r;
    int        pick;
    int        slot;
    r = release_req(ADDR_W'({$urandom(), $urandom()}));
    slot = (pool_used > 0) ? $urandom_range(pool_used - 1) : 0;
    pick = $urandom_range(99);
    if ($urandom_range(99) < 55) begin
      r.kind = REQ_ALLOC;
      if (pick < 40 && pool_used > 0) begin
        r.bytes = pool_cap[slot] + $urandom_range(2) - 1;
      end else if (pick < 70) begin
        r.bytes = $urandom_range(256);
      end else if (pick < 75) begin
        r.bytes = '0;
      end else if (pick < 80) begin
        r.bytes = '1;
      end
      pick = $urandom_range(99);
      if (pick < 10 && pool_used > 0) begin
        r.fresh_base = pool_base[$urandom_range(pool_used - 1)];
      end else if (pick < 15) begin
        r.fresh_base = '0;
      end
    end else begin
      if (pick < 70 && pool_used > 0) begin
        r.release_addr = pool_base[slot];
      end else if (pick < 80) begin
        r.release_addr = '0;
      end
    end
    return r;
  endfunction

  // Sends one item; returns at the edge where it is accepted, with valid still high.
  task automatic send_request(input pool_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid        <= 1'b1;
    req_if.req_type     <= r.kind;
    req_if.req_bytes    <= r.bytes;
    req_if.fresh_base   <= r.fresh_base;
    req_if.fresh_ok     <= r.fresh_ok;
    req_if.release_addr <= r.release_addr;
    do @(posedge clk); while (!req_if.ready);
    outcomes_due.insert(outcomes_due.size(), pool_outcome(r));
    requests_sent++;
  endtask

  // Stops sending and waits until every outstanding result has come back.
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (outcomes_due.size() != 0) @(posedge clk);
  endtask

  // Writes the entry limit once the pool is idle.
  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    wait_drained();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    entry_limit = value;
  endtask

  // Releases into an empty pool and a failed external allocation.
  task automatic test_empty_pool();
    send_request(release_req('0));
    send_request(release_req('1));
    send_request(alloc_req(32'd10, ADDR_W'(48'h0000_1000_0000), 1'b0));
  endtask

  // Growth up to a small limit, with extreme sizes and bases, then pool full.
  task automatic test_growth_limit();
    write_limit(LIMIT_W'(3));
    send_request(alloc_req(32'd100, '0, 1'b1));
    send_request(alloc_req('0, '1, 1'b1));
    send_request(alloc_req('1, ADDR_W'(48'h8000_0000_0001), 1'b1));
    send_request(alloc_req(32'd5, ADDR_W'(48'h0000_2000_0000), 1'b1));
  endtask

  // Release of address zero, of a busy slot, of a free slot, and of an unknown address.
  task automatic test_release_cases();
    send_request(release_req('0));
    send_request(release_req('1));
    send_request(release_req('1));
    send_request(release_req(ADDR_W'(48'h1234_5678_9abc)));
  endtask

  // Best fit, ties on capacity and duplicate bases.
  task automatic test_best_fit();
    send_request(alloc_req('0, ADDR_W'(48'h0000_3000_0000), 1'b1));
    write_limit(LIMIT_W'(7));
    send_request(alloc_req(32'd64, ADDR_W'(48'h0000_4000_0000), 1'b1));
    send_request(alloc_req(32'd64, ADDR_W'(48'h0000_4000_0000), 1'b1));
    send_request(alloc_req(32'd64, ADDR_W'(48'h0000_5000_0000), 1'b1));
    send_request(alloc_req(32'd32, ADDR_W'(48'h0000_6000_0000), 1'b1));
    send_request(release_req(ADDR_W'(48'h0000_5000_0000)));
    send_request(release_req(ADDR_W'(48'h0000_4000_0000)));
    send_request(release_req(ADDR_W'(48'h0000_6000_0000)));
    send_request(alloc_req(32'd40, ADDR_W'(48'h0000_7000_0000), 1'b1));
    send_request(alloc_req(32'd32, ADDR_W'(48'h0000_7000_0000), 1'b1));
    send_request(alloc_req(32'd33, ADDR_W'(48'h0000_7000_0000), 1'b1));
    send_request(alloc_req(32'd65, ADDR_W'(48'h0000_7000_0000), 1'b1));
  endtask

  // A run of random traffic under one limit and one idling pattern.
  task automatic test_random_traffic(input logic [LIMIT_W-1:0] limit, input int count,
                                     input int send_pct, input int recv_pct,
                                     input bit pause_midway);
    int n;
    write_limit(limit);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (n = 0; n < count; n++) begin
      // Hold the sender off once until the pool has caught up completely.
      if (pause_midway && n == count / 2) begin
        wait_drained();
      end
      send_request(random_request());
    end
  endtask

  // Receiver: ready stalls at random according to the current pattern.
  always @(posedge clk) begin
    rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compares each accepted result with the oldest outstanding outcome.
  always @(posedge clk) begin : check_results
    pool_rsp_t due;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      results_seen++;
      if (rsp_if.status < 6) begin
        status_seen[rsp_if.status]++;
      end
      if (outcomes_due.size() == 0) begin
        $error("result with nothing outstanding: status %0d", rsp_if.status);
        mismatches++;
      end else begin
        due = outcomes_due.pop_front();
        if (rsp_if.status !== due.status) begin
          $error("status: expected %0d, got %0d", due.status, rsp_if.status);
          mismatches++;
        end
        if (rsp_if.slot_index !== due.index) begin
          $error("slot_index: expected %0d, got %0d", due.index, rsp_if.slot_index);
          mismatches++;
        end
        if (rsp_if.base_addr !== due.base) begin
          $error("base_addr: expected %h, got %h", due.base, rsp_if.base_addr);
          mismatches++;
        end
        if (rsp_if.grant_bytes !== due.bytes) begin
          $error("grant_bytes: expected %h, got %h", due.bytes, rsp_if.grant_bytes);
          mismatches++;
        end
      end
    end
  end

  // Test sequence.
  initial begin
    rst                 <= 1'b1;
    req_if.valid        <= 1'b0;
    req_if.req_type     <= REQ_ALLOC;
    req_if.req_bytes    <= '0;
    req_if.fresh_base   <= '0;
    req_if.fresh_ok     <= 1'b0;
    req_if.release_addr <= '0;
    cfg_if.valid        <= 1'b0;
    cfg_if.data         <= '0;
    pool_used     = 0;
    entry_limit   = '0;
    send_idle_pct = 11;
    recv_idle_pct = 87;
    requests_sent = 0;
    results_seen  = 0;
    mismatches    = 0;
    foreach (status_seen[k]) status_seen[k] = 0;
    foreach (pool_busy[k]) begin
      pool_busy[k] = 1'b0;
      pool_base[k] = '0;
      pool_cap[k]  = '0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_empty_pool();
    test_growth_limit();
    test_release_cases();
    test_best_fit();
    test_random_traffic(LIMIT_W'(10), 542, 11, 87, 1'b1);
    test_random_traffic(LIMIT_W'(31), 542, 87, 11, 1'b0);
    test_random_traffic(LIMIT_W'(0), 271, 0, 0, 1'b0);
    test_random_traffic(LIMIT_W'(16), 271, 0, 0, 1'b0);

    // Let the last results arrive and give any stray result time to show up.
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("tb_top: %0d requests sent, %0d results checked, final pool size %0d",
             requests_sent, results_seen, pool_used);
    $display("tb_top: reused %0d, new %0d, alloc fail %0d, pool full %0d, released %0d, %s %0d",
             status_seen[ST_REUSED], status_seen[ST_NEW], status_seen[ST_ALLOC_FAIL],
             status_seen[ST_POOL_FULL], status_seen[ST_RELEASED], "not in pool",
             status_seen[ST_NOT_IN_POOL]);
    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
